FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the frame sync block.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define IFSC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define IFSC_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

FILE: rtl/ifsc_pkg.sv
// Package for the frame sync and checksum block: sizes, reset values,
// register indexes and the structs passed between front, queue and back.
package ifsc_pkg;
	localparam int FRAME_LENGTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int BYTE_W = 8;
	localparam int INDEX_W = 5;
	localparam int REG_IDX_W = 8;

	localparam logic [BYTE_W-1:0] FIRST_SYNC_RST = 8'h55;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'hAA;

	localparam logic [REG_IDX_W-1:0] REG_FIRST_SYNC = 8'd0;
	localparam logic [REG_IDX_W-1:0] REG_SECOND_SYNC = 8'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
	} sync_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_first;
		logic              is_second;
	} rx_item_t;

	typedef struct packed {
		logic     valid;
		rx_item_t item;
	} q_head_t;
endpackage

FILE: rtl/ifsc_front.sv
// Front end: sync pattern registers, configuration port and classification
// of each received byte against the sync pattern. Uses ifsc_pkg.
module ifsc_front
	import ifsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 q_full,
	output logic                 push,
	output rx_item_t             push_item,
	output sync_cfg_t            sync_cfg
);
	sync_cfg_t sync_q;

	assign cfg_ready = 1'b1;
	assign sync_cfg = sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q.first <= FIRST_SYNC_RST;
			sync_q.second <= SECOND_SYNC_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST_SYNC: begin
					sync_q.first <= cfg_data;
				end
				REG_SECOND_SYNC: begin
					sync_q.second <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall = q_full;
	assign push = in_valid && !q_full;
	assign push_item.data = rx_byte;
	assign push_item.is_first = (rx_byte == sync_q.first);
	assign push_item.is_second = (rx_byte == sync_q.second);
endmodule

FILE: rtl/ifsc_queue.sv
// Short queue of classified bytes between the front end and the frame engine.
// Uses ifsc_pkg for the entry types.
module ifsc_queue
	import ifsc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rx_item_t push_item,
	output logic     full,
	output q_head_t  head,
	input  logic     pop
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	rx_item_t        entries_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [NW-1:0]   cnt_q;
	logic            do_pop;

	assign full = (cnt_q == NW'(DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.item = entries_q[rd_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/ifsc_back.sv
// Frame engine: frame store, sync hunt, checksum sweep, resync copy and
// frame emission through the output register. Uses ifsc_pkg.
module ifsc_back
	import ifsc_pkg::*;
#(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_head_t            head,
	output logic               pop,
	input  sync_cfg_t          sync_cfg,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  frame_byte,
	output logic [INDEX_W-1:0] byte_index,
	output logic               last
);
	localparam int AW = $clog2(FRAME_LENGTH);
	localparam int CW = $clog2(FRAME_LENGTH + 1);
	localparam logic [CW-1:0] LEN = CW'(FRAME_LENGTH);
	localparam logic [CW-1:0] LAST_POS = CW'(FRAME_LENGTH - 1);
	localparam logic [CW-1:0] SUM_END = CW'(FRAME_LENGTH - 2);
	localparam logic [CW-1:0] SUM_START = CW'(2);

	typedef enum logic [3:0] {
		ST_RUN  = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_COPY = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

	back_state_t         state_q;
	logic [BYTE_W-1:0]   store [FRAME_LENGTH];
	logic [BYTE_W-1:0]   rdata_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       base_q;
	logic [BYTE_W-1:0]   sum_q;
	logic [BYTE_W-1:0]   tail_q;
	logic                prev_first_q;
	logic                found_q;
	logic                sw_vld_s1;
	logic [CW-1:0]       sw_addr_s1;
	logic [AW-1:0]       sw_dst_s1;
	logic                out_valid_q;
	logic [INDEX_W-1:0]  index_q;
	logic                last_q;

	logic                sum_issue;
	logic                copy_issue;
	logic                emit_issue;
	logic                rd_en;
	logic                sum_done;
	logic                copy_done;
	logic                pair_tail;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [BYTE_W-1:0]   wdata;
	logic [CW-1:0]       copy_dst;

	assign pop = (state_q == ST_RUN) && head.valid;

	assign sum_issue = (state_q == ST_SUM) && !out_valid_q && (ptr_q <= SUM_END);
	assign copy_issue = (state_q == ST_COPY) && (ptr_q != LEN);
	assign emit_issue = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign rd_en = sum_issue || copy_issue || emit_issue;
	assign sum_done = (state_q == ST_SUM) && (ptr_q > SUM_END) && !sw_vld_s1;
	assign copy_done = (state_q == ST_COPY) && (ptr_q == LEN) && !sw_vld_s1;
	assign pair_tail = prev_first_q && (tail_q == sync_cfg.second);
	assign copy_dst = ptr_q - base_q;

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = head.item.data;
		if (pop) begin
			waddr = fill_q[AW-1:0];
			if (fill_q == '0) begin
				we = head.item.is_first;
			end else if (fill_q == CW'(1)) begin
				if (head.item.is_second) begin
					we = 1'b1;
				end else if (head.item.is_first) begin
					we = 1'b1;
					waddr = '0;
				end
			end else begin
				we = 1'b1;
			end
		end else if ((state_q == ST_COPY) && sw_vld_s1) begin
			we = 1'b1;
			waddr = sw_dst_s1;
			wdata = rdata_q;
		end else if (sum_done && (sum_q != tail_q) && !found_q && !pair_tail &&
				(tail_q == sync_cfg.first)) begin
			we = 1'b1;
			waddr = '0;
			wdata = tail_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= store[ptr_q[AW-1:0]];
		end
		sw_addr_s1 <= ptr_q;
		sw_dst_s1 <= copy_dst[AW-1:0];
		if (emit_issue) begin
			index_q <= INDEX_W'(ptr_q);
			last_q <= (ptr_q == LAST_POS);
		end
		if (pop && (fill_q == LAST_POS)) begin
			tail_q <= head.item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			fill_q <= '0;
			ptr_q <= '0;
			base_q <= '0;
			sum_q <= '0;
			prev_first_q <= 1'b0;
			found_q <= 1'b0;
			sw_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sw_vld_s1 <= sum_issue || copy_issue;
			if (emit_issue) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				ptr_q <= ptr_q + 1'b1;
			end
			case (state_q)
				ST_RUN: begin
					if (pop) begin
						if (fill_q == '0) begin
							if (head.item.is_first) begin
								fill_q <= CW'(1);
							end
						end else if (fill_q == CW'(1)) begin
							if (head.item.is_second) begin
								fill_q <= CW'(2);
							end else if (!head.item.is_first) begin
								fill_q <= '0;
							end
						end else if (fill_q == LAST_POS) begin
							state_q <= ST_SUM;
							ptr_q <= SUM_START;
							sum_q <= '0;
							prev_first_q <= 1'b0;
							found_q <= 1'b0;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_SUM: begin
					if (sw_vld_s1) begin
						sum_q <= sum_q + rdata_q;
						prev_first_q <= (rdata_q == sync_cfg.first);
						if (!found_q && prev_first_q && (rdata_q == sync_cfg.second)) begin
							found_q <= 1'b1;
							base_q <= sw_addr_s1 - 1'b1;
						end
					end
					if (sum_done) begin
						if (sum_q == tail_q) begin
							state_q <= ST_EMIT;
							ptr_q <= '0;
						end else if (found_q) begin
							state_q <= ST_COPY;
							ptr_q <= base_q;
						end else if (pair_tail) begin
							state_q <= ST_COPY;
							ptr_q <= SUM_END;
							base_q <= SUM_END;
						end else begin
							state_q <= ST_RUN;
							fill_q <= (tail_q == sync_cfg.first) ? CW'(1) : '0;
						end
					end
				end
				ST_COPY: begin
					if (copy_done) begin
						state_q <= ST_RUN;
						fill_q <= LEN - base_q;
					end
				end
				ST_EMIT: begin
					if (emit_issue && (ptr_q == LAST_POS)) begin
						state_q <= ST_RUN;
						fill_q <= '0;
					end
				end
				default: begin
					state_q <= ST_RUN;
					fill_q <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign frame_byte = rdata_q;
	assign byte_index = index_q;
	assign last = last_q;
endmodule

FILE: rtl/imu_frame_sync_checksum.sv
// Top level of the sync word deframer with additive checksum.
// Instantiates ifsc_front, ifsc_queue and ifsc_back; uses ifsc_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  input    | in        | in_valid / in_stall  | rx_byte
//  output   | out       | out_valid / out_stall| frame_byte, byte_index, last
//  config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The frame engine takes one queued byte per cycle while collecting. A full
// frame starts a checksum sweep of FRAME_LENGTH-3 store reads through the
// single store read port. A good frame then leaves at one byte per cycle
// without stalls; a bad frame costs up to FRAME_LENGTH-2 copy reads on the
// same port. Reset is asynchronous and needs no clearing pass; output stalls
// hold only the output register and the checksum sweep behind it, while the
// queue keeps filling.
module imu_frame_sync_checksum
	import ifsc_pkg::*;
#(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    frame_byte,
	output logic [INDEX_W-1:0]   byte_index,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);
	logic      q_full;
	logic      push;
	rx_item_t  push_item;
	sync_cfg_t sync_cfg;
	q_head_t   head;
	logic      pop;

	ifsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item),
		.sync_cfg  (sync_cfg)
	);

	ifsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.head      (head),
		.pop       (pop)
	);

	ifsc_back #(
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.sync_cfg   (sync_cfg),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last       (last)
	);
endmodule

FILE: rtl/ifsc_checker.sv
// Port-level checker for the frame sync block, bound to the top level.
// Uses ifsc_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module ifsc_checker
	import ifsc_pkg::*;
#(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [BYTE_W-1:0]  rx_byte,
	input logic               out_valid,
	input logic               out_stall,
	input logic [BYTE_W-1:0]  frame_byte,
	input logic [INDEX_W-1:0] byte_index,
	input logic               last
);
	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FRAME_LENGTH - 1);

	// A stalled result keeps its payload.
	`IFSC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(byte_index) && $stable(last))

	// A stalled input byte keeps its value.
	`IFSC_ASSERT(a_in_hold, clk, arst_n, in_valid && in_stall |=> in_valid && $stable(rx_byte))

	// The last byte of a frame sits at the final position.
	`IFSC_ASSERT(a_last_pos, clk, arst_n, out_valid && last |-> byte_index == LAST_INDEX)

	// Within a frame the next byte follows at once with the next position.
	`IFSC_ASSERT(a_index_step, clk, arst_n, out_valid && !out_stall && !last |=> out_valid && (byte_index == $past(byte_index) + 5'd1))
endmodule

bind imu_frame_sync_checksum ifsc_checker #(
	.FRAME_LENGTH (FRAME_LENGTH)
) u_ifsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.rx_byte    (rx_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.byte_index (byte_index),
	.last       (last)
);
